FILE: rtl/utf8_cyrillic_transliterator_defines.svh
// Assertion macros shared by the transliterator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef UTF8_CYRILLIC_TRANSLITERATOR_DEFINES_SVH
`define UTF8_CYRILLIC_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UCX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UCX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ucx_pkg.sv
// Package for the UTF-8 Cyrillic transliterator: types, sizes and letter table.
// No dependencies.
package ucx_pkg;

	localparam int TEXT_W = 32;          // up to four Latin characters
	localparam int LEN_W  = 3;           // character count 0..4
	localparam int IDX_W  = 2;           // character index 0..3
	localparam logic [7:0] LEAD_MIN = 8'h80;

	// Result of one table lookup; text is left aligned, first character on top
	typedef struct packed {
		logic              hit;
		logic [LEN_W-1:0]  len;
		logic [TEXT_W-1:0] text;
	} letter_t;

	// One run of result beats handed to the output stage
	typedef struct packed {
		logic              has;
		logic              str_end;
		logic [LEN_W-1:0]  len;
		logic [TEXT_W-1:0] text;
	} run_t;

	// Build a hit entry from a right-aligned literal
	function automatic letter_t mk(input logic [LEN_W-1:0] len, input logic [TEXT_W-1:0] s);
		letter_t r;
		r.hit  = 1'b1;
		r.len  = len;
		r.text = s << {3'd4 - len, 3'b000};
		return r;
	endfunction

	// Two-byte UTF-8 Russian letter to Latin text
	function automatic letter_t letter_lookup(input logic [7:0] lead, input logic [7:0] trail);
		letter_t r;
		r = '0;
		case ({lead, trail})
			// lower case
			16'hD0B0: r = mk(3'd1, "a");
			16'hD0B1: r = mk(3'd1, "b");
			16'hD0B2: r = mk(3'd1, "v");
			16'hD0B3: r = mk(3'd1, "g");
			16'hD0B4: r = mk(3'd1, "d");
			16'hD0B5: r = mk(3'd1, "e");
			16'hD191: r = mk(3'd2, "yo");
			16'hD0B6: r = mk(3'd2, "zh");
			16'hD0B7: r = mk(3'd1, "z");
			16'hD0B8: r = mk(3'd1, "i");
			16'hD0B9: r = mk(3'd1, "y");
			16'hD0BA: r = mk(3'd1, "k");
			16'hD0BB: r = mk(3'd1, "l");
			16'hD0BC: r = mk(3'd1, "m");
			16'hD0BD: r = mk(3'd1, "n");
			16'hD0BE: r = mk(3'd1, "o");
			16'hD0BF: r = mk(3'd1, "p");
			16'hD180: r = mk(3'd1, "r");
			16'hD181: r = mk(3'd1, "s");
			16'hD182: r = mk(3'd1, "t");
			16'hD183: r = mk(3'd1, "u");
			16'hD184: r = mk(3'd1, "f");
			16'hD185: r = mk(3'd2, "kh");
			16'hD186: r = mk(3'd2, "ts");
			16'hD187: r = mk(3'd2, "ch");
			16'hD188: r = mk(3'd2, "sh");
			16'hD189: r = mk(3'd4, "shch");
			16'hD18A: r = mk(3'd1, "'");
			16'hD18B: r = mk(3'd1, "y");
			16'hD18C: r = mk(3'd1, "'");
			16'hD18D: r = mk(3'd1, "e");
			16'hD18E: r = mk(3'd2, "yu");
			16'hD18F: r = mk(3'd2, "ya");
			// upper case
			16'hD090: r = mk(3'd1, "A");
			16'hD091: r = mk(3'd1, "B");
			16'hD092: r = mk(3'd1, "V");
			16'hD093: r = mk(3'd1, "G");
			16'hD094: r = mk(3'd1, "D");
			16'hD095: r = mk(3'd1, "E");
			16'hD081: r = mk(3'd2, "Yo");
			16'hD096: r = mk(3'd2, "Zh");
			16'hD097: r = mk(3'd1, "Z");
			16'hD098: r = mk(3'd1, "I");
			16'hD099: r = mk(3'd1, "Y");
			16'hD09A: r = mk(3'd1, "K");
			16'hD09B: r = mk(3'd1, "L");
			16'hD09C: r = mk(3'd1, "M");
			16'hD09D: r = mk(3'd1, "N");
			16'hD09E: r = mk(3'd1, "O");
			16'hD09F: r = mk(3'd1, "P");
			16'hD0A0: r = mk(3'd1, "R");
			16'hD0A1: r = mk(3'd1, "S");
			16'hD0A2: r = mk(3'd1, "T");
			16'hD0A3: r = mk(3'd1, "U");
			16'hD0A4: r = mk(3'd1, "F");
			16'hD0A5: r = mk(3'd2, "Kh");
			16'hD0A6: r = mk(3'd2, "Ts");
			16'hD0A7: r = mk(3'd2, "Ch");
			16'hD0A8: r = mk(3'd2, "Sh");
			16'hD0A9: r = mk(3'd4, "Shch");
			16'hD0AA: r = mk(3'd1, "'");
			16'hD0AB: r = mk(3'd1, "Y");
			16'hD0AC: r = mk(3'd1, "'");
			16'hD0AD: r = mk(3'd1, "E");
			16'hD0AE: r = mk(3'd2, "Yu");
			16'hD0AF: r = mk(3'd2, "Ya");
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/ucx_if.sv
// Valid/ready channel interfaces for the transliterator's byte input and char output.
// No dependencies.
interface ucx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_last;

	modport source (output valid, output in_byte, output string_last, input ready);
	modport sink (input valid, input in_byte, input string_last, output ready);
endinterface

interface ucx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_char, output has_char, output run_last,
		output string_end, input ready);
	modport sink (input valid, input out_char, input has_char, input run_last,
		input string_end, output ready);
endinterface

FILE: rtl/ucx_drain.sv
// Result register and serializer: holds one run of up to four chars, one beat per cycle while chars.ready is high.
// Depends on ucx_pkg, ucx_if.sv and utf8_cyrillic_transliterator_defines.svh.
`include "utf8_cyrillic_transliterator_defines.svh"

module ucx_drain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ucx_pkg::run_t   run,
	output logic            free,
	ucx_out_if.source       chars
);

	logic                      valid_q;
	logic [ucx_pkg::IDX_W-1:0] idx_q;
	ucx_pkg::run_t             run_q;
	logic                      last_beat;
	logic [ucx_pkg::TEXT_W-1:0] sel;

	// Beat position within the run
	assign last_beat = ({1'b0, idx_q} == run_q.len - 3'd1);
	assign free      = !valid_q || (chars.ready && last_beat);

	// Run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && chars.ready) begin
			if (last_beat) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Run payload
	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

	// Pick the current character from the top of the shifted text
	assign sel = run_q.text << {idx_q, 3'b000};

	assign chars.valid      = valid_q;
	assign chars.out_char   = sel[ucx_pkg::TEXT_W-1 -: 8];
	assign chars.has_char   = run_q.has;
	assign chars.run_last   = last_beat;
	assign chars.string_end = last_beat && run_q.str_end;

	`UCX_ASSERT_NOW(a_len_nonzero, clk, arst_n, valid_q, run_q.len != 3'd0, "empty run in output stage")
	`UCX_ASSERT_NOW(a_idx_in_run, clk, arst_n, valid_q, {1'b0, idx_q} < run_q.len, "beat index past run length")
	`UCX_ASSERT_NOW(a_marker_ends, clk, arst_n, valid_q && !run_q.has, last_beat && run_q.str_end, "bare marker not at string end")

endmodule

FILE: rtl/utf8_cyrillic_transliterator.sv
// UTF-8 Cyrillic-to-Latin transliterator top level.
// Depends on ucx_pkg, ucx_if.sv, ucx_drain and utf8_cyrillic_transliterator_defines.svh.
//
// Channels: "bytes" takes one UTF-8 byte per beat with string_last on the final
// byte; "chars" gives one result per beat (out_char, has_char, run_last,
// string_end). ASCII bytes pass through; a two-byte Russian letter gives 1 to 4
// Latin characters; an unknown pair gives nothing, except a bare end marker when
// it closes the string. A lead byte gives no result.
// Timing: an accepted byte sits in the input register, is looked up and loaded into
// the result register once the output stage is free; its first char can then be taken.
// Output: the output stage sends one char per cycle while the receiver holds ready high;
// an item yields 1 to 4 chars, four for the shch letters; items with no result leave
// the input register without waiting for the output stage.
// Stalls: while the receiver holds ready low the current run stays put, the input
// register keeps one more item, and then bytes.ready drops.
// Reset: arst_n clears the held lead byte and all valid state; no clearing pass.
`include "utf8_cyrillic_transliterator_defines.svh"

module utf8_cyrillic_transliterator (
	input  logic      clk,
	input  logic      arst_n,
	ucx_in_if.sink    bytes,
	ucx_out_if.source chars
);

	logic          held_valid_q;
	logic [7:0]    held_lead_q;
	logic          valid_s1;
	logic          pair_s1;
	logic [7:0]    lead_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic          accept;
	logic          hold;
	logic          drop;
	logic          adv;
	logic          load;
	logic          free;
	ucx_pkg::letter_t lk;
	ucx_pkg::run_t    run_d;

	// Input handshake
	assign accept      = bytes.valid && bytes.ready;
	assign hold        = !held_valid_q && (bytes.in_byte >= ucx_pkg::LEAD_MIN) && !bytes.string_last;
	assign adv         = valid_s1 && (drop || free);
	assign load        = valid_s1 && !drop && free;
	assign bytes.ready = !valid_s1 || adv;

	// Lead byte store and input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_lead_q  <= '0;
			valid_s1     <= 1'b0;
		end else if (accept) begin
			held_valid_q <= hold;
			held_lead_q  <= hold ? bytes.in_byte : 8'h00;
			valid_s1     <= !hold;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1 <= held_valid_q;
			lead_s1 <= held_lead_q;
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.string_last;
		end
	end

	// Letter lookup and run build
	assign lk   = ucx_pkg::letter_lookup(lead_s1, byte_s1);
	assign drop = pair_s1 && !lk.hit && !last_s1;

	always_comb begin
		run_d.str_end = last_s1;
		if (!pair_s1) begin
			run_d.has  = 1'b1;
			run_d.len  = 3'd1;
			run_d.text = {byte_s1, 24'h000000};
		end else if (lk.hit) begin
			run_d.has  = 1'b1;
			run_d.len  = lk.len;
			run_d.text = lk.text;
		end else begin
			run_d.has  = 1'b0;
			run_d.len  = 3'd1;
			run_d.text = '0;
		end
	end

	ucx_drain u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.run    (run_d),
		.free   (free),
		.chars  (chars)
	);

	`UCX_ASSERT_NEXT(a_pair_loads, clk, arst_n, accept && held_valid_q, !held_valid_q && valid_s1 && pair_s1, "held pair not formed")
	`UCX_ASSERT_NEXT(a_hold_no_s1, clk, arst_n, accept && hold, held_valid_q && !valid_s1, "lead byte entered input register")
	`UCX_ASSERT_NOW(a_raw_kept, clk, arst_n, valid_s1 && !pair_s1, !drop, "pass-through byte dropped")

endmodule
